/* hdl/mmwm_pkg.sv */
// ----------------------------------------------------------------------------
// mmwm_pkg: shared definitions for the mask window marker
// Constants, register indexes, operation codes and the small structs that
// travel between the marker's modules.
// ----------------------------------------------------------------------------
package mmwm_pkg;

	localparam int MAX_COLS_DEF = 1024;
	localparam int WINDOW_DEF   = 7;
	localparam int MAX_ROWS     = 4096;

	localparam int ROWS_REG_W = 13;
	localparam int COLS_REG_W = 11;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 13'd1024;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd1024;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [7:0] MASK_CLEAR = 8'd0;
	localparam logic [7:0] MASK_SET   = 8'd255;

	// result queue depth, power of two
	localparam int OUT_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS = 1'b0,
		REG_FRAME_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		FX_IDLE,
		FX_TOTAL,
		FX_CLAMP,
		FX_DIV
	} fix_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ls_ctrl_t;

	typedef struct packed {
		logic has_zero;
		logic has_full;
	} cell_flags_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/mmwm_cell.sv */
// ----------------------------------------------------------------------------
// mmwm_cell: one column of the sliding window
// Holds a window column, takes its neighbor's column on every shift and
// reports whether the column holds a clear or a set mask byte.
// ----------------------------------------------------------------------------
module mmwm_cell #(
	parameter int WINDOW = mmwm_pkg::WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift,
	input  logic [WINDOW-1:0][7:0]       in_col,
	input  logic                         in_ok,
	output logic [WINDOW-1:0][7:0]       col,
	output logic                         ok,
	output mmwm_pkg::cell_flags_t        flags
);

	logic [WINDOW-1:0][7:0] col_q;
	logic                   ok_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= in_col;
		end
	end

	// ok tracks the centre row of this column only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (shift) begin
			ok_q <= in_ok;
		end
	end

	always_comb begin
		flags.has_zero = 1'b0;
		flags.has_full = 1'b0;
		for (int k = 0; k < WINDOW; k++) begin
			if (col_q[k] == mmwm_pkg::MASK_CLEAR) begin
				flags.has_zero = 1'b1;
			end
			if (col_q[k] == mmwm_pkg::MASK_SET) begin
				flags.has_full = 1'b1;
			end
		end
	end

	assign col = col_q;
	assign ok  = ok_q;

endmodule

/* hdl/mmwm_line_store.sv */
// ----------------------------------------------------------------------------
// mmwm_line_store: line memory for the rows above the current one
// One word per column holds the stored rows and their valid bits. Registered
// read, one write per cycle, forwarding for a read of the column written in
// the same cycle, and a fill count for columns never written.
// ----------------------------------------------------------------------------
module mmwm_line_store #(
	parameter int MAX_COLS = mmwm_pkg::MAX_COLS_DEF,
	parameter int WINDOW   = mmwm_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmwm_pkg::ls_ctrl_t            ctrl,
	input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
	input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
	input  logic [WINDOW-2:0][7:0]        wr_col,
	input  logic [WINDOW-2:0]             wr_ok,
	output logic [WINDOW-2:0][7:0]        rd_col,
	output logic [WINDOW-2:0]             rd_ok
);

	localparam int FW = $clog2(MAX_COLS + 1);
	localparam int OW = WINDOW - 1;
	localparam int DW = (WINDOW - 1) * 8;

	logic [OW+DW-1:0] mem [MAX_COLS];
	logic [OW+DW-1:0] rd_word_q;
	logic [OW+DW-1:0] hold_q;
	logic [OW+DW-1:0] word;
	logic             fwd_q;
	logic             fill_ok_q;
	logic [FW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= {wr_ok, wr_col};
			hold_q       <= {wr_ok, wr_col};
		end
		if (ctrl.rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// columns are written in order from 0, so the written ones form a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q     <= 1'b0;
			fill_ok_q <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (ctrl.rd_en) begin
				fwd_q     <= ctrl.wr_en && (wr_addr == rd_addr);
				fill_ok_q <= FW'(rd_addr) < fill_q;
			end
			if (ctrl.wr_en && (FW'(wr_addr) >= fill_q)) begin
				fill_q <= FW'(wr_addr) + FW'(1);
			end
		end
	end

	always_comb begin
		word   = fwd_q ? hold_q : rd_word_q;
		rd_col = word[DW-1:0];
		rd_ok  = word[OW+DW-1:DW] & {OW{fwd_q | fill_ok_q}};
	end

endmodule

/* hdl/mmwm_pos_div.sv */
// ----------------------------------------------------------------------------
// mmwm_pos_div: serial position divider
// Restoring division, one quotient bit per cycle; splits a raster position
// into row and column after the frame geometry changes.
// ----------------------------------------------------------------------------
module mmwm_pos_div #(
	parameter int POS_W = $clog2(mmwm_pkg::MAX_ROWS * mmwm_pkg::MAX_COLS_DEF),
	parameter int DIV_W = $clog2(mmwm_pkg::MAX_COLS_DEF + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [POS_W-1:0]     dividend,
	input  logic [DIV_W-1:0]     divisor,
	output mmwm_pkg::div_stat_t  stat,
	output logic [POS_W-1:0]     quotient,
	output logic [DIV_W-1:0]     remainder
);

	localparam int CW = $clog2(POS_W);

	logic [POS_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             take;

	always_comb begin
		trial = {rem_q, quo_q[POS_W-1]};
		take  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[POS_W-2:0], take};
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/mask_mixed_window_marker_top.sv */
// ----------------------------------------------------------------------------
// mask_mixed_window_marker_top: 7x7 boundary marker for an occlusion mask
// Streams an 8-bit mask in raster order and marks pixels whose full window
// holds both a clear (0) and a set (255) byte.
// ----------------------------------------------------------------------------
// Mask bytes enter in raster order, one per clock while in_stall is low; each
// accepted pixel or boundary drain shifts the window by one slot. Results lag
// the input by (WINDOW-1-WINDOW/2) rows plus as many pixels, 3 rows plus 3
// pixels for the 7x7 window; a result is passed through unchanged unless its
// pixel is the centre of a window lying wholly inside the frame, in which case
// it reads 255 when that window holds at least one 0 and at least one 255.
// The sustained rate is one transaction per clock while in_stall is low:
// the line store does one read and one write per clock, and a result is
// pushed into the output queue from stage 2, after the stage 1 store read.
// Drain transactions are taken only at a frame boundary (elsewhere they are
// dropped) and flush the tail of the frame. After reset and after every
// register write, the block recomputes the frame geometry (total, clamp,
// divide), with input stalled and cfg_ready low.
// ----------------------------------------------------------------------------
module mask_mixed_window_marker_top #(
	parameter int MAX_COLS = mmwm_pkg::MAX_COLS_DEF,
	parameter int WINDOW   = mmwm_pkg::WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input transactions
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [7:0]                         mask_value,
	// result transactions
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         marked_value,
	output logic                               frame_last,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mmwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int H      = WINDOW / 2;          // rows/cols before centre
	localparam int A      = WINDOW - 1 - H;      // rows/cols after centre
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ECW    = $clog2(MAX_COLS + 1);
	localparam int CX_W   = ECW + 1;
	localparam int ROW_W  = $clog2(mmwm_pkg::MAX_ROWS);
	localparam int REW    = mmwm_pkg::ROWS_REG_W;
	localparam int POS_W  = $clog2(mmwm_pkg::MAX_ROWS * MAX_COLS);
	localparam int TOT_W  = POS_W + 1;
	localparam int PTR_W  = $clog2(mmwm_pkg::OUT_DEPTH);
	localparam int CNT_W  = $clog2(mmwm_pkg::OUT_DEPTH + 1);

	// ---------------- configuration registers ----------------
	logic [mmwm_pkg::ROWS_REG_W-1:0] rows_q;
	logic [mmwm_pkg::COLS_REG_W-1:0] cols_q;
	logic [REW-1:0]                  rows_eff;
	logic [ECW-1:0]                  cols_eff;
	logic                            cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mmwm_pkg::ROWS_RESET;
			cols_q <= mmwm_pkg::COLS_RESET;
		end else if (cfg_we) begin
			case (mmwm_pkg::reg_idx_t'(cfg_index))
				mmwm_pkg::REG_FRAME_ROWS: begin
					rows_q <= cfg_data;
				end
				mmwm_pkg::REG_FRAME_COLS: begin
					cols_q <= cfg_data[mmwm_pkg::COLS_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// saturate to 1..MAX_ROWS and 1..MAX_COLS; zero counts as one
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = REW'(1);
		end else if (int'(rows_q) > mmwm_pkg::MAX_ROWS) begin
			rows_eff = REW'(mmwm_pkg::MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == '0) begin
			cols_eff = ECW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			cols_eff = ECW'(MAX_COLS);
		end else begin
			cols_eff = ECW'(cols_q);
		end
	end

	// ---------------- geometry fixup sequencer ----------------
	mmwm_pkg::fix_state_t fx_state_q;
	mmwm_pkg::fix_state_t fx_next;
	logic                 fx_load_total;
	logic                 fx_clamp;
	logic                 fx_busy;
	mmwm_pkg::div_stat_t  div_stat;
	logic [POS_W-1:0]     div_quo;
	logic [ECW-1:0]       div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_state_q <= mmwm_pkg::FX_TOTAL;
		end else begin
			fx_state_q <= fx_next;
		end
	end

	always_comb begin
		fx_next = fx_state_q;
		case (fx_state_q)
			mmwm_pkg::FX_IDLE: begin
				if (cfg_we) begin
					fx_next = mmwm_pkg::FX_TOTAL;
				end
			end
			mmwm_pkg::FX_TOTAL: begin
				fx_next = mmwm_pkg::FX_CLAMP;
			end
			mmwm_pkg::FX_CLAMP: begin
				fx_next = mmwm_pkg::FX_DIV;
			end
			mmwm_pkg::FX_DIV: begin
				if (div_stat.done) begin
					fx_next = mmwm_pkg::FX_IDLE;
				end
			end
			default: begin
				fx_next = mmwm_pkg::FX_TOTAL;
			end
		endcase
	end

	always_comb begin
		fx_load_total = 1'b0;
		fx_clamp      = 1'b0;
		fx_busy       = 1'b1;
		cfg_ready     = 1'b0;
		case (fx_state_q)
			mmwm_pkg::FX_IDLE: begin
				fx_busy   = 1'b0;
				cfg_ready = 1'b1;
			end
			mmwm_pkg::FX_TOTAL: begin
				fx_load_total = 1'b1;
			end
			mmwm_pkg::FX_CLAMP: begin
				fx_clamp = 1'b1;
			end
			mmwm_pkg::FX_DIV: begin
			end
			default: begin
			end
		endcase
	end

	logic [TOT_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOT_W'(1);
		end else if (fx_load_total) begin
			total_q <= TOT_W'(rows_eff) * TOT_W'(cols_eff);
		end
	end

	// ---------------- positions ----------------
	logic [POS_W-1:0] in_pos_q;
	logic [POS_W-1:0] out_pos_q;
	logic [POS_W-1:0] out_pos_clamped;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [COL_W-1:0] pipe_col_q;

	assign out_pos_clamped = (TOT_W'(out_pos_q) >= total_q) ? '0 : out_pos_q;

	mmwm_pos_div #(
		.POS_W (POS_W),
		.DIV_W (ECW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (fx_clamp),
		.dividend  (out_pos_clamped),
		.divisor   (cols_eff),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ---------------- input side ----------------
	logic accept;
	logic drain;
	logic shift;

	assign accept = in_valid && !in_stall;
	assign drain  = (operation == mmwm_pkg::OP_DRAIN);
	// a drain inside a frame is dropped: no shift, no result
	assign shift  = accept && !(drain && (in_pos_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			pipe_col_q <= '0;
		end else if (fx_clamp) begin
			if (TOT_W'(in_pos_q) >= total_q) begin
				in_pos_q <= '0;
			end
			if (ECW'(pipe_col_q) >= cols_eff) begin
				pipe_col_q <= '0;
			end
		end else begin
			if (accept && !drain) begin
				if ((TOT_W'(in_pos_q) + TOT_W'(1)) >= total_q) begin
					in_pos_q <= '0;
				end else begin
					in_pos_q <= in_pos_q + POS_W'(1);
				end
			end
			if (shift) begin
				if ((ECW'(pipe_col_q) + ECW'(1)) >= cols_eff) begin
					pipe_col_q <= '0;
				end else begin
					pipe_col_q <= pipe_col_q + COL_W'(1);
				end
			end
		end
	end

	// stage 1: line store read is in flight
	logic             shift_s1;
	logic [7:0]       value_s1;
	logic             ok_s1;
	logic [COL_W-1:0] addr_s1;
	logic             eval_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			eval_s2  <= 1'b0;
		end else begin
			shift_s1 <= shift;
			eval_s2  <= shift_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_s1 <= drain ? mmwm_pkg::MASK_CLEAR : mask_value;
			ok_s1    <= !drain;
			addr_s1  <= pipe_col_q;
		end
	end

	// ---------------- line store ----------------
	mmwm_pkg::ls_ctrl_t     ls_ctrl;
	logic [WINDOW-2:0][7:0] ls_col;
	logic [WINDOW-2:0]      ls_ok;
	logic [WINDOW-1:0][7:0] new_col;
	logic [WINDOW-1:0]      new_ok;
	logic [WINDOW-2:0][7:0] wr_col;
	logic [WINDOW-2:0]      wr_ok;

	assign ls_ctrl.rd_en = shift;
	assign ls_ctrl.wr_en = shift_s1;

	mmwm_line_store #(
		.MAX_COLS (MAX_COLS),
		.WINDOW   (WINDOW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ls_ctrl),
		.rd_addr (pipe_col_q),
		.wr_addr (addr_s1),
		.wr_col  (wr_col),
		.wr_ok   (wr_ok),
		.rd_col  (ls_col),
		.rd_ok   (ls_ok)
	);

	// new window column: stored rows on top, incoming byte at the bottom;
	// the store keeps the column moved up by one row
	always_comb begin
		for (int k = 0; k < WINDOW - 1; k++) begin
			new_col[k] = ls_col[k];
			new_ok[k]  = ls_ok[k];
		end
		new_col[WINDOW-1] = value_s1;
		new_ok[WINDOW-1]  = ok_s1;
		for (int k = 0; k < WINDOW - 1; k++) begin
			wr_col[k] = new_col[k+1];
			wr_ok[k]  = new_ok[k+1];
		end
	end

	// ---------------- window: chain of column cells ----------------
	logic [WINDOW-1:0][WINDOW-1:0][7:0] cell_col;
	logic [WINDOW-1:0]                  cell_ok;
	mmwm_pkg::cell_flags_t              cell_flags [WINDOW];

	for (genvar j = 0; j < WINDOW; j++) begin : g_cell
		logic [WINDOW-1:0][7:0] cin;
		logic                   cin_ok;
		if (j == WINDOW - 1) begin : g_head
			assign cin    = new_col;
			assign cin_ok = new_ok[H];
		end else begin : g_link
			assign cin    = cell_col[j+1];
			assign cin_ok = cell_ok[j+1];
		end
		mmwm_cell #(
			.WINDOW (WINDOW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift_s1),
			.in_col (cin),
			.in_ok  (cin_ok),
			.col    (cell_col[j]),
			.ok     (cell_ok[j]),
			.flags  (cell_flags[j])
		);
	end

	// ---------------- result evaluation (stage 2) ----------------
	logic       any_zero;
	logic       any_full;
	logic       full_win;
	logic       push;
	logic       push_last;
	logic       pos_wrap;
	logic [7:0] mark;

	always_comb begin
		any_zero = 1'b0;
		any_full = 1'b0;
		for (int j = 0; j < WINDOW; j++) begin
			any_zero = any_zero | cell_flags[j].has_zero;
			any_full = any_full | cell_flags[j].has_full;
		end
		full_win = (out_row_q >= ROW_W'(H))
			&& ((REW'(out_row_q) + REW'(A)) < rows_eff)
			&& (out_col_q >= COL_W'(H))
			&& ((CX_W'(out_col_q) + CX_W'(A)) < CX_W'(cols_eff));
		mark      = (full_win && any_zero && any_full) ? mmwm_pkg::MASK_SET : cell_col[H][H];
		push      = eval_s2 && cell_ok[H];
		pos_wrap  = (TOT_W'(out_pos_q) + TOT_W'(1)) >= total_q;
		push_last = TOT_W'(out_pos_q) == (total_q - TOT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pos_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (fx_clamp) begin
			out_pos_q <= out_pos_clamped;
		end else if (div_stat.done) begin
			out_row_q <= div_quo[ROW_W-1:0];
			out_col_q <= div_rem[COL_W-1:0];
		end else if (push) begin
			if (pos_wrap) begin
				out_pos_q <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				out_pos_q <= out_pos_q + POS_W'(1);
				if ((ECW'(out_col_q) + ECW'(1)) == cols_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------- result queue ----------------
	logic [7:0]       fifo_val_q  [mmwm_pkg::OUT_DEPTH];
	logic             fifo_last_q [mmwm_pkg::OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0]   committed;
	logic             pop;

	assign out_valid    = (cnt_q != '0);
	assign pop          = out_valid && !out_stall;
	assign marked_value = fifo_val_q[rd_ptr_q];
	assign frame_last   = fifo_last_q[rd_ptr_q];

	// room is reserved for every transaction still in the pipeline
	assign committed = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(shift_s1) + (CNT_W+1)'(eval_s2);
	assign in_stall  = fx_busy || (committed >= (CNT_W+1)'(mmwm_pkg::OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_val_q[wr_ptr_q]  <= mark;
			fifo_last_q[wr_ptr_q] <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// ---------------- assertions ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(mmwm_pkg::OUT_DEPTH))
		else $error("result queue over its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((cnt_q < CNT_W'(mmwm_pkg::OUT_DEPTH)) || pop))
		else $error("result pushed into a full queue");

	a_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && drain && (in_pos_q != '0)) |=> !shift_s1)
		else $error("drain inside a frame shifted the window");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fx_state_q == mmwm_pkg::FX_IDLE) |-> (TOT_W'(out_pos_q) < total_q))
		else $error("output position beyond the frame");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_last) |=> (out_pos_q == '0))
		else $error("frame end did not restart the output position");

endmodule
